// ===== design/fpfa_pkg.sv =====
package fpfa_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_ALT   = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic [1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [1:0] REG_PART_COUNT = 2'd1;

  localparam int REQ_BITS  = 16;
  localparam int CFG_BITS  = 5;
  localparam int GIDX_BITS = 4;

  typedef struct packed {
    op_e                   opcode;
    logic [3:0]            partition_index;
    logic [REQ_BITS-1:0]   size_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [GIDX_BITS-1:0]  granted_index;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic sample;
  } fit_ctl_t;

endpackage

// ===== design/fixed_partition_fit_allocator_top.sv =====
// fixed-partition fit allocator
// in channel (in_valid/in_stall/in_data) carries one item: a load of one
// partition size, an allocate request of a given size, a clear of all
// occupancy, or a no-op. out channel (out_valid/out_stall/out_data) returns
// exactly one result item per input item, in order.
// cfg port (cfg_we/cfg_index/cfg_wdata) sets fit policy (index 0) and the
// number of searched partitions (index 1); write only while idle.
// load, clear and no-op go from accept to the finish state, then to the output register.
// an allocate walks the partitions below the count through one shared set of
// size comparators, one partition per cycle, behind a registered table read.
// in_stall is high from accept until the result is loaded into the output
// register; a result waiting there does not block the next accept, but the
// following result waits until out_stall drops.
// reset clears all occupied bits, sets fit policy to first fit and the
// count to 16; partition sizes are undefined until loaded.
module fixed_partition_fit_allocator_top
  import fpfa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int LIM_W = $clog2(NUM_PARTITIONS + 1);
  localparam int CMP_W = (LIM_W > CFG_BITS) ? LIM_W : CFG_BITS;

  fsm_e                state_r, state_nxt;
  policy_e             policy_r;
  logic [CFG_BITS-1:0] count_r;
  op_e                 op_r;
  logic [REQ_BITS-1:0] req_r;
  logic [LIM_W-1:0]    limit_r;
  logic [LIM_W-1:0]    limit_w;
  logic [IDX_W-1:0]    scan_addr_r;
  logic                issue_done_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                busy_q_r;
  logic [NUM_PARTITIONS-1:0] busy_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                in_acc;
  logic                issue;
  logic                last_issue;
  logic                last_read;
  logic                fin_go;
  logic                load_we;
  logic [SIZE_BITS-1:0] rd_size;
  logic                found;
  logic [IDX_W-1:0]    pick_idx;
  fit_ctl_t            fit_ctl;

  always_comb begin
    if (CMP_W'(count_r) > CMP_W'(NUM_PARTITIONS)) begin
      limit_w = LIM_W'(NUM_PARTITIONS);
    end else begin
      limit_w = LIM_W'(count_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == OP_ALLOC && limit_w != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (last_read) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    in_acc     = in_valid && (state_r == S_IDLE);
    issue      = (state_r == S_SCAN) && !issue_done_r;
    last_issue = LIM_W'(scan_addr_r) == (limit_r - LIM_W'(1));
    last_read  = rd_vld_r && (LIM_W'(rd_idx_r) == (limit_r - LIM_W'(1)));
    fin_go     = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
    load_we    = in_acc && (in_data.opcode == OP_LOAD) &&
                 (32'(in_data.partition_index) < 32'(NUM_PARTITIONS));
    fit_ctl.start  = in_acc;
    fit_ctl.sample = rd_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      count_r  <= CFG_BITS'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY: policy_r <= policy_e'(cfg_wdata[1:0]);
        REG_PART_COUNT: count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_data.opcode;
      req_r   <= in_data.size_value;
      limit_r <= limit_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r  <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (in_acc) begin
        scan_addr_r  <= '0;
        issue_done_r <= 1'b0;
      end else if (issue) begin
        if (last_issue) begin
          issue_done_r <= 1'b1;
        end else begin
          scan_addr_r <= scan_addr_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
    busy_q_r <= busy_r[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (in_acc && in_data.opcode == OP_CLEAR) begin
      busy_r <= '0;
    end else if (fin_go && op_r == OP_ALLOC && found) begin
      busy_r[pick_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (op_r == OP_ALLOC && found) begin
        out_data_r.status        <= ST_GRANT;
        out_data_r.granted_index <= GIDX_BITS'(pick_idx);
      end else if (op_r == OP_ALLOC) begin
        out_data_r.status        <= ST_NONE;
        out_data_r.granted_index <= '0;
      end else begin
        out_data_r.status        <= ST_DONE;
        out_data_r.granted_index <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fpfa_ram #(
    .DEPTH (NUM_PARTITIONS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(in_data.partition_index)),
    .wdata (SIZE_BITS'(in_data.size_value)),
    .raddr (scan_addr_r),
    .rdata (rd_size)
  );

  fpfa_fit_unit #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fit_ctl),
    .policy   (policy_r),
    .req      (req_r),
    .rd_idx   (rd_idx_r),
    .rd_size  (rd_size),
    .rd_busy  (busy_q_r),
    .found    (found),
    .pick_idx (pick_idx)
  );

`ifndef SYNTH
  a_rd_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == S_SCAN)
    else $error("table read outside scan");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FINISH))
    else $error("result without finish state");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_GRANT) |-> out_data.granted_index == '0)
    else $error("nonzero index without grant");

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && op_r == OP_ALLOC && found) |=> busy_r[$past(pick_idx)])
    else $error("granted partition not marked busy");
`endif

endmodule

// ===== design/fpfa_ram.sv =====
module fpfa_ram
  import fpfa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fpfa_fit_unit.sv =====
module fpfa_fit_unit
  import fpfa_pkg::*;
#(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fit_ctl_t             ctl,
  input  policy_e              policy,
  input  logic [REQ_BITS-1:0]  req,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic [SIZE_BITS-1:0] rd_size,
  input  logic                 rd_busy,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx
);

  localparam int CW = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;

  logic                 found_r;
  logic [IDX_W-1:0]     pick_idx_r;
  logic [SIZE_BITS-1:0] pick_size_r;
  logic                 elig;
  logic                 take;

  // one set of size comparators shared by every partition of the walk
  always_comb begin
    elig = !rd_busy && (CW'(rd_size) >= CW'(req));
    take = 1'b0;
    if (elig) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (policy == POL_BEST) begin
        take = rd_size < pick_size_r;
      end else if (policy == POL_WORST) begin
        take = rd_size > pick_size_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (ctl.sample && take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample && take) begin
      pick_idx_r  <= rd_idx;
      pick_size_r <= rd_size;
    end
  end

  assign found    = found_r;
  assign pick_idx = pick_idx_r;

endmodule
